// ----- rtl/lz77twd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lz77twd_pkg
// Shared types, constants and helpers of the LZ77 triplet window decoder.
// ----------------------------------------------------------------------------
package lz77twd_pkg;

    localparam int WINDOW_DEPTH_DEF = 65536;
    localparam int RUN_MAX_DEF      = 64;

    localparam int SYM_W = 8;
    localparam int LEN_W = 32;
    localparam int OFF_W = 16;
    localparam int ERR_W = 2;

    // length symbol that carries on into the next symbol
    localparam logic [SYM_W-1:0] SYM_RUN = 8'hFF;

    typedef enum logic [2:0] {
        PH_LITLEN,
        PH_LIT,
        PH_MATCHLEN,
        PH_OFFHI,
        PH_OFFLO
    } t_phase;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE,
        ERR_OFFSET,
        ERR_FORMAT
    } t_err;

    typedef enum logic {
        CMD_SYMBOL,
        CMD_CONTINUE
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LITSUM,
        S_PREP,
        S_COPY_RD,
        S_COPY_WR,
        S_STAT
    } t_ctrl_state;

    typedef struct packed {
        logic accept;
        logic lit_sum;
        logic prep;
        logic copy_rd;
        logic copy_wr;
        logic stat;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic go_prep;
        logic go_litsum;
        logic copy_nonzero;
        logic run_last;
    } t_dp_stat;

    function automatic logic [LEN_W-1:0] sat_add32(input logic [LEN_W-1:0] a,
                                                   input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? '1 : s[LEN_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lz77twd_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lz77twd_in_if
// Symbol request channel: command and decoded symbol with valid/ready.
// ----------------------------------------------------------------------------
interface lz77twd_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [lz77twd_pkg::SYM_W-1:0]  symbol;

    modport source (output valid, output command, output symbol, input ready);
    modport sink   (input valid, input command, input symbol, output ready);
endinterface
`default_nettype wire

// ----- rtl/lz77twd_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lz77twd_out_if
// Result request channel: decoded byte and decoder status with valid/ready.
// ----------------------------------------------------------------------------
interface lz77twd_out_if;
    logic                           valid;
    logic                           ready;
    logic [lz77twd_pkg::SYM_W-1:0]  out_byte;
    logic                           byte_valid;
    logic                           last;
    logic                           copy_pending;
    logic                           finished;
    logic [lz77twd_pkg::ERR_W-1:0]  error_code;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output copy_pending, output finished, output error_code,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last,
                    input copy_pending, input finished, input error_code,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/lz77twd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lz77twd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lz77twd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

// ----- rtl/lz77twd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lz77twd_ctrl
// Sequencer: takes requests, steps match copies through the history RAM.
// ----------------------------------------------------------------------------
module lz77twd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  lz77twd_pkg::t_dp_stat i_stat,
    output logic                  o_in_ready,
    output lz77twd_pkg::t_dp_cmd  o_cmd
);
    import lz77twd_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.out_free) begin
                    if (i_stat.go_prep) begin
                        n_state = S_PREP;
                    end else if (i_stat.go_litsum) begin
                        n_state = S_LITSUM;
                    end
                end
            end
            S_LITSUM: begin
                n_state = S_IDLE;
            end
            S_PREP: begin
                n_state = i_stat.copy_nonzero ? S_COPY_RD : S_STAT;
            end
            S_COPY_RD: begin
                n_state = S_COPY_WR;
            end
            S_COPY_WR: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.run_last ? S_IDLE : S_COPY_RD;
                end
            end
            S_STAT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = i_stat.out_free;
                o_cmd.accept = i_in_valid && i_stat.out_free;
            end
            S_LITSUM: begin
                o_cmd.lit_sum = 1'b1;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
            end
            S_COPY_RD: begin
                o_cmd.copy_rd = 1'b1;
            end
            S_COPY_WR: begin
                o_cmd.copy_wr = i_stat.out_free;
            end
            S_STAT: begin
                o_cmd.stat = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/lz77twd_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lz77twd_dp
// Datapath: triplet parsing, length counters, history ring and result register.
// ----------------------------------------------------------------------------
module lz77twd_dp #(
    parameter int WINDOW_DEPTH = lz77twd_pkg::WINDOW_DEPTH_DEF,
    parameter int RUN_MAX      = lz77twd_pkg::RUN_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [lz77twd_pkg::LEN_W-1:0]  i_cfg_wr_data,
    input  logic                           i_command,
    input  logic [lz77twd_pkg::SYM_W-1:0]  i_symbol,
    input  lz77twd_pkg::t_dp_cmd           i_cmd,
    input  logic                           i_out_ready,
    output lz77twd_pkg::t_dp_stat          o_stat,
    output logic                           o_out_valid,
    output logic [lz77twd_pkg::SYM_W-1:0]  o_out_byte,
    output logic                           o_out_byte_valid,
    output logic                           o_out_last,
    output logic                           o_out_copy_pending,
    output logic                           o_out_finished,
    output logic [lz77twd_pkg::ERR_W-1:0]  o_out_error_code
);
    import lz77twd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int RW = $clog2(RUN_MAX + 1);
    localparam int DW = 18;

    logic [LEN_W-1:0] r_src, n_src;
    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_lit_total, n_lit_total;
    logic [LEN_W-1:0] r_lit_left, n_lit_left;
    logic [LEN_W-1:0] r_match_total, n_match_total;
    logic [OFF_W-1:0] r_match_off, n_match_off;
    logic [AW-1:0]    r_wr_idx, n_wr_idx;
    logic [FW-1:0]    r_fill, n_fill;
    logic [LEN_W-1:0] r_dec, n_dec;
    logic [AW-1:0]    r_cp_idx, n_cp_idx;
    logic [LEN_W-1:0] r_cp_left, n_cp_left;
    logic             r_done, n_done;
    t_err             r_err, n_err;
    logic [RW-1:0]    r_run, n_run;

    logic             r_out_valid, n_out_valid;
    logic [SYM_W-1:0] r_out_byte, n_out_byte;
    logic             r_out_bvalid, n_out_bvalid;
    logic             r_out_last, n_out_last;
    logic             r_out_pend, n_out_pend;
    logic             r_out_fin, n_out_fin;
    t_err             r_out_err, n_out_err;

    logic [LEN_W-1:0] w_lt_sum;
    logic [LEN_W-1:0] w_mt_sum;
    logic [LEN_W-1:0] w_dc_lit;
    logic [LEN_W-1:0] w_dc_match;
    logic [OFF_W-1:0] w_off;
    logic             w_off_bad;
    logic             w_zero_trip;
    logic [DW-1:0]    w_diff;
    logic [AW-1:0]    w_cp_start;
    logic             w_is_offlo;
    logic             w_sym_ok;
    logic             w_go_prep;
    logic             w_go_litsum;
    logic             w_lit_wr;
    logic             w_run_fin;
    logic [RW-1:0]    w_run;
    logic             w_out_free;
    logic             w_load_acc;
    logic             w_ram_we;
    logic [SYM_W-1:0] w_ram_wd;
    logic [SYM_W-1:0] w_rd_data;
    logic [AW-1:0]    w_wr_idx_inc;
    logic [AW-1:0]    w_cp_idx_inc;
    logic [FW-1:0]    w_fill_inc;

    assign w_lt_sum    = sat_add32(r_lit_total, LEN_W'(i_symbol));
    assign w_mt_sum    = sat_add32(r_match_total, LEN_W'(i_symbol));
    assign w_dc_lit    = sat_add32(r_dec, r_lit_total);
    assign w_dc_match  = sat_add32(r_dec, r_match_total);
    assign w_off       = {r_match_off[OFF_W-1:SYM_W], i_symbol};
    assign w_off_bad   = {1'b0, w_off} >= (OFF_W+1)'(r_fill);
    assign w_zero_trip = (r_lit_total == '0) && (r_match_total == '0);
    assign w_diff      = DW'(r_wr_idx) - DW'(w_off) - DW'(1);
    assign w_cp_start  = w_diff[DW-1] ? AW'(w_diff + DW'(WINDOW_DEPTH)) : AW'(w_diff);

    assign w_is_offlo  = (r_phase != PH_LITLEN) && (r_phase != PH_LIT)
                      && (r_phase != PH_MATCHLEN) && (r_phase != PH_OFFHI);
    assign w_sym_ok    = !r_done && (i_command == CMD_SYMBOL) && (r_cp_left == '0);
    assign w_go_prep   = !r_done
                      && (((i_command == CMD_CONTINUE) && (r_cp_left != '0))
                      || (w_sym_ok && w_is_offlo && !w_off_bad && !w_zero_trip));
    assign w_go_litsum = w_sym_ok && (r_phase == PH_LITLEN) && (i_symbol != SYM_RUN);
    assign w_lit_wr    = i_cmd.accept && w_sym_ok && (r_phase == PH_LIT);

    assign w_run_fin   = r_cp_left <= LEN_W'(RUN_MAX);
    assign w_run       = w_run_fin ? r_cp_left[RW-1:0] : RW'(RUN_MAX);

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_load_acc  = i_cmd.accept && !w_go_prep;

    assign w_ram_we    = w_lit_wr || i_cmd.copy_wr;
    assign w_ram_wd    = i_cmd.copy_wr ? w_rd_data : i_symbol;

    assign w_wr_idx_inc = (r_wr_idx == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wr_idx + AW'(1);
    assign w_cp_idx_inc = (r_cp_idx == AW'(WINDOW_DEPTH - 1)) ? '0 : r_cp_idx + AW'(1);
    assign w_fill_inc   = (r_fill == FW'(WINDOW_DEPTH)) ? r_fill : r_fill + FW'(1);

    lz77twd_ram #(
        .WIDTH (SYM_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (w_ram_wd),
        .i_rd_en   (i_cmd.copy_rd),
        .i_rd_addr (r_cp_idx),
        .o_rd_data (w_rd_data)
    );

    // decoder state
    always_comb begin
        n_src         = r_src;
        n_phase       = r_phase;
        n_lit_total   = r_lit_total;
        n_lit_left    = r_lit_left;
        n_match_total = r_match_total;
        n_match_off   = r_match_off;
        n_wr_idx      = r_wr_idx;
        n_fill        = r_fill;
        n_dec         = r_dec;
        n_cp_idx      = r_cp_idx;
        n_cp_left     = r_cp_left;
        n_done        = r_done;
        n_err         = r_err;
        n_run         = r_run;

        if (i_cfg_wr_en) begin
            n_src = i_cfg_wr_data;
        end

        if (i_cmd.accept && w_sym_ok) begin
            case (r_phase)
                PH_LITLEN: begin
                    n_lit_total = w_lt_sum;
                    if (i_symbol != SYM_RUN) begin
                        n_lit_left = w_lt_sum;
                        n_phase    = (w_lt_sum == '0) ? PH_MATCHLEN : PH_LIT;
                    end
                end
                PH_LIT: begin
                    if (r_lit_left != '0) begin
                        n_lit_left = r_lit_left - LEN_W'(1);
                    end
                    if (r_lit_left <= LEN_W'(1)) begin
                        n_phase = PH_MATCHLEN;
                    end
                end
                PH_MATCHLEN: begin
                    n_match_total = w_mt_sum;
                    if (i_symbol != SYM_RUN) begin
                        n_phase = PH_OFFHI;
                    end
                end
                PH_OFFHI: begin
                    n_match_off = {i_symbol, SYM_W'(0)};
                    n_phase     = PH_OFFLO;
                end
                default: begin
                    n_match_off = w_off;
                    if (w_off_bad || w_zero_trip) begin
                        n_err         = w_off_bad ? ERR_OFFSET : ERR_FORMAT;
                        n_done        = 1'b1;
                        n_lit_total   = '0;
                        n_lit_left    = '0;
                        n_match_total = '0;
                        n_match_off   = '0;
                        n_phase       = PH_LITLEN;
                    end else begin
                        n_cp_idx  = w_cp_start;
                        n_cp_left = r_match_total;
                    end
                end
            endcase
        end

        if (i_cmd.lit_sum) begin
            n_dec = w_dc_lit;
        end

        // size the run and settle the triplet if it ends in this request
        if (i_cmd.prep) begin
            n_run     = w_run;
            n_cp_left = r_cp_left - LEN_W'(w_run);
            if (w_run_fin) begin
                n_dec = w_dc_match;
                if (w_dc_match > r_src) begin
                    n_err = ERR_FORMAT;
                end
                if (w_dc_match >= r_src) begin
                    n_done = 1'b1;
                end
                n_lit_total   = '0;
                n_lit_left    = '0;
                n_match_total = '0;
                n_match_off   = '0;
                n_phase       = PH_LITLEN;
            end
        end

        if (w_ram_we) begin
            n_wr_idx = w_wr_idx_inc;
            n_fill   = w_fill_inc;
        end

        if (i_cmd.copy_wr) begin
            n_cp_idx = w_cp_idx_inc;
            n_run    = r_run - RW'(1);
        end
    end

    // result register
    always_comb begin
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_byte   = r_out_byte;
        n_out_bvalid = r_out_bvalid;
        n_out_last   = r_out_last;
        n_out_pend   = r_out_pend;
        n_out_fin    = r_out_fin;
        n_out_err    = r_out_err;
        if (w_load_acc) begin
            n_out_valid  = 1'b1;
            n_out_byte   = w_lit_wr ? i_symbol : '0;
            n_out_bvalid = w_lit_wr;
            n_out_last   = 1'b1;
            n_out_pend   = n_cp_left != '0;
            n_out_fin    = n_done;
            n_out_err    = n_err;
        end else if (i_cmd.copy_wr) begin
            n_out_valid  = 1'b1;
            n_out_byte   = w_rd_data;
            n_out_bvalid = 1'b1;
            n_out_last   = r_run == RW'(1);
            n_out_pend   = r_cp_left != '0;
            n_out_fin    = r_done;
            n_out_err    = r_err;
        end else if (i_cmd.stat) begin
            n_out_valid  = 1'b1;
            n_out_byte   = '0;
            n_out_bvalid = 1'b0;
            n_out_last   = 1'b1;
            n_out_pend   = r_cp_left != '0;
            n_out_fin    = r_done;
            n_out_err    = r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src         <= '0;
            r_phase       <= PH_LITLEN;
            r_lit_total   <= '0;
            r_lit_left    <= '0;
            r_match_total <= '0;
            r_match_off   <= '0;
            r_wr_idx      <= '0;
            r_fill        <= '0;
            r_dec         <= '0;
            r_cp_idx      <= '0;
            r_cp_left     <= '0;
            r_done        <= 1'b0;
            r_err         <= ERR_NONE;
            r_run         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_src         <= n_src;
            r_phase       <= n_phase;
            r_lit_total   <= n_lit_total;
            r_lit_left    <= n_lit_left;
            r_match_total <= n_match_total;
            r_match_off   <= n_match_off;
            r_wr_idx      <= n_wr_idx;
            r_fill        <= n_fill;
            r_dec         <= n_dec;
            r_cp_idx      <= n_cp_idx;
            r_cp_left     <= n_cp_left;
            r_done        <= n_done;
            r_err         <= n_err;
            r_run         <= n_run;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_out_bvalid <= n_out_bvalid;
        r_out_last   <= n_out_last;
        r_out_pend   <= n_out_pend;
        r_out_fin    <= n_out_fin;
        r_out_err    <= n_out_err;
    end

    assign o_stat.out_free     = w_out_free;
    assign o_stat.go_prep      = w_go_prep;
    assign o_stat.go_litsum    = w_go_litsum;
    assign o_stat.copy_nonzero = r_cp_left != '0;
    assign o_stat.run_last     = r_run == RW'(1);

    assign o_out_valid        = r_out_valid;
    assign o_out_byte         = r_out_byte;
    assign o_out_byte_valid   = r_out_bvalid;
    assign o_out_last         = r_out_last;
    assign o_out_copy_pending = r_out_pend;
    assign o_out_finished     = r_out_fin;
    assign o_out_error_code   = r_out_err;
endmodule
`default_nettype wire

// ----- rtl/lz77_triplet_window_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lz77_triplet_window_decoder
// LZ77 decoder for triplets of already decoded symbols, history ring in RAM.
// ----------------------------------------------------------------------------
// Each request carries one symbol (literal length, literal, match length,
// offset high, offset low) or a continue command, and yields one or more
// results; every result carries the status as it stands after that request.
// A literal or status-only request uses the idle state alone, one ending a
// literal length also the literal-sum state, one closing a triplet with an
// empty match the prepare and status states. A request copying match bytes
// uses the idle and prepare states, then a read and a write state per byte
// (at most RUN_MAX bytes per request): each byte is read from the history RAM
// (registered read), then written back and presented in the next cycle. A
// held result stalls the decoder. History RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module lz77_triplet_window_decoder #(
    parameter int WINDOW_DEPTH = lz77twd_pkg::WINDOW_DEPTH_DEF,
    parameter int RUN_MAX      = lz77twd_pkg::RUN_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [lz77twd_pkg::LEN_W-1:0] i_cfg_wr_data,
    lz77twd_in_if.sink                    i_in,
    lz77twd_out_if.source                 o_out
);
    import lz77twd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    lz77twd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    lz77twd_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .RUN_MAX      (RUN_MAX)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_command          (i_in.command),
        .i_symbol           (i_in.symbol),
        .i_cmd              (w_cmd),
        .i_out_ready        (o_out.ready),
        .o_stat             (w_stat),
        .o_out_valid        (o_out.valid),
        .o_out_byte         (o_out.out_byte),
        .o_out_byte_valid   (o_out.byte_valid),
        .o_out_last         (o_out.last),
        .o_out_copy_pending (o_out.copy_pending),
        .o_out_finished     (o_out.finished),
        .o_out_error_code   (o_out.error_code)
    );

    assign i_in.ready = w_in_ready;
endmodule
`default_nettype wire
